[rtl/iol_pkg.sv]
// package for the indexed ordered list: codes, widths and the cell command beat
`timescale 1ns / 1ps
`default_nettype none
package iol_pkg;

    // fixed field widths
    localparam int DATA_W    = 32;
    localparam int FUNC_W    = 3;
    localparam int POS_W     = 10;
    localparam int STATUS_W  = 2;

    // widest cell index and compare width over the capacity range (up to 4096)
    localparam int IDX_MAX_W = 12;
    localparam int CMP_W     = 13;

    // default capacity and read gather group size
    localparam int DEF_CAPACITY = 256;
    localparam int GRP          = 16;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD_HEAD  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_ADD_TAIL  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_ADD_INDEX = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DELETE    = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // value returned when nothing is read
    localparam logic [DATA_W-1:0] NOT_FOUND = '1;

    // shift command broadcast to every cell
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_DELETE
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [IDX_MAX_W-1:0] pos;
        logic [DATA_W-1:0]    value;
        logic [IDX_MAX_W-1:0] rd_pos;
    } t_cell_cmd;

endpackage
`default_nettype wire

[rtl/iol_cell.sv]
// one list cell: holds an entry and shifts with its neighbors on insert or delete
`timescale 1ns / 1ps
`default_nettype none
module iol_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                      i_clk,
    input  wire iol_pkg::t_cell_cmd        i_cmd,
    input  wire logic [iol_pkg::DATA_W-1:0] i_left,
    input  wire logic [iol_pkg::DATA_W-1:0] i_right,
    output logic      [iol_pkg::DATA_W-1:0] o_value,
    output logic      [iol_pkg::DATA_W-1:0] o_tap
);
    import iol_pkg::*;

    localparam logic [IDX_MAX_W-1:0] CELL_IDX = IDX_MAX_W'(INDEX);

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;

    // next entry from the broadcast command
    always_comb begin
        n_value = r_value;
        case (i_cmd.op)
            CMD_INSERT: begin
                if (CELL_IDX == i_cmd.pos) begin
                    n_value = i_cmd.value;
                end else if (CELL_IDX > i_cmd.pos) begin
                    n_value = i_left;
                end
            end
            CMD_DELETE: begin
                if (CELL_IDX >= i_cmd.pos) begin
                    n_value = i_right;
                end
            end
            default: n_value = r_value;
        endcase
    end

    // entry storage, undefined until written
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

    // read tap: drives the entry only when addressed
    assign o_tap = (CELL_IDX == i_cmd.rd_pos) ? r_value : '0;

endmodule
`default_nettype wire

[rtl/iol_group.sv]
// read gather: registered or of one group of cell taps
`timescale 1ns / 1ps
`default_nettype none
module iol_group #(
    parameter int N = iol_pkg::GRP
) (
    input  wire logic                       i_clk,
    input  wire logic [iol_pkg::DATA_W-1:0] i_tap [N],
    output logic      [iol_pkg::DATA_W-1:0] o_or
);
    import iol_pkg::*;

    logic [DATA_W-1:0] w_or;
    logic [DATA_W-1:0] r_or;

    // at most one tap is nonzero
    always_comb begin
        w_or = '0;
        for (int k = 0; k < N; k++) begin
            w_or = w_or | i_tap[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_or <= w_or;
    end

    assign o_or = r_or;

endmodule
`default_nettype wire

[rtl/indexed_ordered_list.sv]
// top level of the indexed ordered list: decode, row of cells, read gather, result
// a taken start beat passes the first stage, then the result registers raise o_valid
// throughput: one item per cycle unless busy; the whole row shifts in the accept cycle
// the read path is the cell taps, a registered or per group of cells, then a final or
// reset: synchronous active low, clears the length; entries stay undefined until written
// busy is high only through reset and the cycle after; results cannot be stalled
`timescale 1ns / 1ps
`default_nettype none
module indexed_ordered_list #(
    parameter int CAPACITY = iol_pkg::DEF_CAPACITY,
    localparam int LEN_W   = $clog2(CAPACITY + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [iol_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [iol_pkg::POS_W-1:0]    i_position,
    input  wire logic signed [iol_pkg::DATA_W-1:0] i_value,
    output logic                              o_valid,
    output logic signed [iol_pkg::DATA_W-1:0] o_read_value,
    output logic      [iol_pkg::STATUS_W-1:0] o_status,
    output logic      [LEN_W-1:0]             o_length
);
    import iol_pkg::*;

    localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

    // control state
    logic                r_busy;
    logic [LEN_W-1:0]    r_count;
    logic [LEN_W-1:0]    n_count;
    logic                w_accept;
    logic                w_full;
    logic [CMP_W-1:0]    w_pos;
    logic [CMP_W-1:0]    w_len;
    t_cell_cmd           w_cmd;
    logic [STATUS_W-1:0] w_status;
    logic                w_hit;

    // first stage
    logic                r_s1_valid;
    logic [STATUS_W-1:0] r_s1_status;
    logic [LEN_W-1:0]    r_s1_len;
    logic                r_s1_hit;

    // row and gather
    logic [DATA_W-1:0] w_val [CAPACITY];
    logic [DATA_W-1:0] w_tap [NGRP*GRP];
    logic [DATA_W-1:0] w_grp [NGRP];
    logic [DATA_W-1:0] w_rd;

    // result registers
    logic                r_valid;
    logic [DATA_W-1:0]   r_read_value;
    logic [STATUS_W-1:0] r_status;
    logic [LEN_W-1:0]    r_length;

    assign busy     = r_busy;
    assign w_accept = start && !r_busy;
    assign w_full   = (r_count == LEN_W'(CAPACITY));
    assign w_pos    = {{(CMP_W-POS_W){1'b0}}, i_position};
    assign w_len    = CMP_W'(r_count);

    // decode the beat into a cell command, status and new length
    always_comb begin
        w_cmd.op     = CMD_HOLD;
        w_cmd.pos    = '0;
        w_cmd.value  = i_value;
        w_cmd.rd_pos = IDX_MAX_W'(i_position);
        w_status     = ST_DONE;
        w_hit        = 1'b0;
        n_count      = r_count;
        unique case (i_func)
            FUNC_READ: begin
                if (w_pos < w_len) begin
                    w_hit = 1'b1;
                end else begin
                    w_status = ST_RANGE;
                end
            end
            FUNC_ADD_HEAD: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.op = CMD_INSERT;
                    n_count  = r_count + LEN_W'(1);
                end
            end
            FUNC_ADD_TAIL: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.op  = CMD_INSERT;
                    w_cmd.pos = IDX_MAX_W'(r_count);
                    n_count   = r_count + LEN_W'(1);
                end
            end
            FUNC_ADD_INDEX: begin
                if (w_pos > w_len) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.op  = CMD_INSERT;
                    w_cmd.pos = IDX_MAX_W'(i_position);
                    n_count   = r_count + LEN_W'(1);
                end
            end
            FUNC_DELETE: begin
                if (w_pos < w_len) begin
                    w_cmd.op  = CMD_DELETE;
                    w_cmd.pos = IDX_MAX_W'(i_position);
                    n_count   = r_count - LEN_W'(1);
                end else begin
                    w_status = ST_RANGE;
                end
            end
            default: w_status = ST_DONE;
        endcase
        if (!w_accept) begin
            w_cmd.op = CMD_HOLD;
            n_count  = r_count;
        end
    end

    // row of cells, each fed by its neighbors
    for (genvar i = 0; i < NGRP*GRP; i++) begin : g_cell
        if (i < CAPACITY) begin : g_live
            iol_cell #(
                .INDEX (i)
            ) u_cell (
                .i_clk   (i_clk),
                .i_cmd   (w_cmd),
                .i_left  ((i == 0) ? w_val[0] : w_val[(i == 0) ? 0 : i-1]),
                .i_right (w_val[(i == CAPACITY-1) ? i : i+1]),
                .o_value (w_val[i]),
                .o_tap   (w_tap[i])
            );
        end else begin : g_pad
            assign w_tap[i] = '0;
        end
    end

    // first gather level
    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        iol_group #(
            .N (GRP)
        ) u_group (
            .i_clk (i_clk),
            .i_tap (w_tap[g*GRP +: GRP]),
            .o_or  (w_grp[g])
        );
    end

    // final gather level
    always_comb begin
        w_rd = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_rd = w_rd | w_grp[g];
        end
    end

    // length, pipeline control and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_count    <= '0;
            r_s1_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_busy     <= 1'b0;
            r_count    <= n_count;
            r_s1_valid <= w_accept;
            r_valid    <= r_s1_valid;
        end
        r_s1_status  <= w_status;
        r_s1_len     <= n_count;
        r_s1_hit     <= w_hit;
        r_read_value <= r_s1_hit ? w_rd : NOT_FOUND;
        r_status     <= r_s1_status;
        r_length     <= r_s1_len;
    end

    assign o_valid      = r_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_length     = r_length;

`ifndef SYNTH
    // every accepted beat gives a result on o_valid after the first stage
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##2 o_valid)
        else $error("result missing after accepted beat");

    // a full status only happens on a full list
    a_full_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_length == LEN_W'(CAPACITY)))
        else $error("full status with list not full");

    // flagged results never carry read data
    a_flag_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_DONE) |-> (o_read_value == NOT_FOUND))
        else $error("read data on a flagged result");

    // length never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LEN_W'(CAPACITY))
        else $error("length above capacity");
`endif

endmodule
`default_nettype wire
